[hdl/sorted_timer_deadline_queue_defines.svh]
// ----------------------------------------------------------------------------
// sorted timer deadline queue assertion macros
// concurrent assertion shorthands used by the queue rtl
// ----------------------------------------------------------------------------
`ifndef SORTED_TIMER_DEADLINE_QUEUE_DEFINES_SVH
`define SORTED_TIMER_DEADLINE_QUEUE_DEFINES_SVH

// clocked check, off while reset is asserted
`define STDQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check, also active during reset
`define STDQ_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[hdl/stdq_pkg.sv]
// ----------------------------------------------------------------------------
// stdq_pkg
// types and constants of the sorted timer deadline queue
// ----------------------------------------------------------------------------
`default_nettype none

package stdq_pkg;

  localparam int Timers    = 32;
  localparam int TickBits  = 32;
  localparam int IdW       = 5;
  localparam int TimerIdxW = $clog2(Timers);

  typedef logic [TickBits-1:0] tick_t;
  typedef logic [IdW-1:0]      id_t;

  typedef enum logic {
    OpAdd    = 1'b0,
    OpRemove = 1'b1
  } op_e;

  typedef struct packed {
    op_e         operation;
    id_t         timer_id;
    logic [31:0] now_tick;
    logic [31:0] period;
    logic        has_action;
  } req_t;

  typedef struct packed {
    logic        status;
    logic        went_to_overflow;
    logic [31:0] deadline;
    id_t         current_head;
    logic        current_nonempty;
    id_t         overflow_head;
    logic        overflow_nonempty;
  } rsp_t;

  typedef struct packed {
    logic  valid;
    id_t   id;
    tick_t dl;
  } cell_t;

  typedef struct packed {
    logic  ins;
    logic  rem;
    logic  strict;
    cell_t entry;
    id_t   rem_id;
  } row_cmd_t;

endpackage

`default_nettype wire

[hdl/stdq_cell.sv]
// ----------------------------------------------------------------------------
// stdq_cell
// one slot of a sorted list: compares, shifts right on insert, left on remove
// ----------------------------------------------------------------------------
`default_nettype none

module stdq_cell
  import stdq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  row_cmd_t cmd_i,
  input  cell_t    left_i,
  input  logic     left_here_i,
  input  logic     left_gone_i,
  input  cell_t    right_i,
  output logic     here_o,
  output logic     gone_o,
  output cell_t    cell_o,
  output cell_t    cell_next_o
);

  logic  valid_q, valid_d;
  id_t   id_q, id_d;
  tick_t dl_q, dl_d;
  cell_t cur, nxt;

  assign cur = '{valid: valid_q, id: id_q, dl: dl_q};

  // insert position: first free slot or one with a later deadline (or an equal one, unless strict)
  assign here_o = !valid_q ||
                  (cmd_i.strict ? (dl_q > cmd_i.entry.dl) : (dl_q >= cmd_i.entry.dl));
  assign gone_o = left_gone_i || (valid_q && (id_q == cmd_i.rem_id));

  always_comb begin
    nxt = cur;
    if (cmd_i.ins) begin
      if (left_here_i) begin
        nxt = left_i;
      end else if (here_o) begin
        nxt = cmd_i.entry;
      end
    end else if (cmd_i.rem) begin
      if (gone_o) begin
        nxt = right_i;
      end
    end
  end

  assign valid_d = nxt.valid;
  assign id_d    = nxt.id;
  assign dl_d    = nxt.dl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
    dl_q <= dl_d;
  end

  assign cell_o      = cur;
  assign cell_next_o = nxt;

endmodule

`default_nettype wire

[hdl/stdq_row.sv]
// ----------------------------------------------------------------------------
// stdq_row
// chain of cells holding one deadline-sorted list, head at cell zero
// ----------------------------------------------------------------------------
`default_nettype none

module stdq_row
  import stdq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  row_cmd_t          cmd_i,
  output cell_t             head_next_o,
  output logic [Timers-1:0] valid_o
);

  cell_t cells   [Timers];
  cell_t nexts   [Timers];
  logic  here_w  [Timers];
  logic  gone_w  [Timers];

  for (genvar i = 0; i < Timers; i++) begin : g_cell
    cell_t left, right;
    logic  left_here, left_gone;

    if (i == 0) begin : g_first
      assign left      = '0;
      assign left_here = 1'b0;
      assign left_gone = 1'b0;
    end else begin : g_mid
      assign left      = cells[i-1];
      assign left_here = here_w[i-1];
      assign left_gone = gone_w[i-1];
    end

    if (i == Timers - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = cells[i+1];
    end

    stdq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd_i),
      .left_i      (left),
      .left_here_i (left_here),
      .left_gone_i (left_gone),
      .right_i     (right),
      .here_o      (here_w[i]),
      .gone_o      (gone_w[i]),
      .cell_o      (cells[i]),
      .cell_next_o (nexts[i])
    );

    assign valid_o[i] = cells[i].valid;
  end

  assign head_next_o = nexts[0];

endmodule

`default_nettype wire

[hdl/sorted_timer_deadline_queue.sv]
// ----------------------------------------------------------------------------
// sorted_timer_deadline_queue
// two deadline-sorted timer lists (current and overflow) kept in cell rows
// ----------------------------------------------------------------------------
// channel   direction  handshake                 payload
// in        request    in_valid_i / in_ready_o   in_req_i  (req_t)
// out       result     out_valid_o / out_ready_i out_rsp_o (rsp_t)
//
// a request is decoded into the pending register, then both cell rows
// compare and shift in parallel while the result register loads
// one request in flight; a waiting result stalls the row update and then intake
// reset empties both lists and stops every timer, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_timer_deadline_queue_defines.svh"

module sorted_timer_deadline_queue
  import stdq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_rsp_o
);

  logic                 pend_q;
  logic                 rsp_valid_q;
  rsp_t                 rsp_q, rsp_d;
  logic [Timers-1:0]    run_q;
  row_cmd_t             cur_cmd_q, ovf_cmd_q, cur_cmd_d, ovf_cmd_d;
  row_cmd_t             cur_cmd, ovf_cmd;
  logic                 ok_q, ok_d;
  logic                 add_q;
  logic [TimerIdxW-1:0] idx_q, idx_d;
  logic                 status_q, status_d;
  logic                 wrap_q, wrap_d;
  logic [31:0]          dl_out_q, dl_out_d;
  cell_t                cur_head, ovf_head;
  logic [Timers-1:0]    cur_valid, ovf_valid;

  logic  accept, apply, is_add, id_ok, run_hit, reject, wrap;
  tick_t now_t, dl;
  cell_t entry;

  assign accept = in_valid_i && in_ready_o;
  assign apply  = pend_q && (!rsp_valid_q || out_ready_i);
  assign in_ready_o = !pend_q;

  // request decode
  assign is_add  = (in_req_i.operation == OpAdd);
  assign id_ok   = (32'(in_req_i.timer_id) < 32'(Timers));
  assign idx_d   = in_req_i.timer_id[TimerIdxW-1:0];
  assign run_hit = run_q[idx_d];
  assign reject  = !id_ok || (is_add ? (!in_req_i.has_action || run_hit) : !run_hit);
  assign ok_d    = !reject;
  assign now_t   = tick_t'(in_req_i.now_tick);
  assign dl      = now_t + tick_t'(in_req_i.period);
  assign wrap    = (dl < now_t);
  assign entry   = '{valid: 1'b1, id: in_req_i.timer_id, dl: dl};

  always_comb begin
    cur_cmd_d        = '0;
    cur_cmd_d.ins    = ok_d && is_add && !wrap;
    cur_cmd_d.rem    = ok_d && !is_add;
    cur_cmd_d.strict = 1'b0;
    cur_cmd_d.entry  = entry;
    cur_cmd_d.rem_id = in_req_i.timer_id;
    ovf_cmd_d        = cur_cmd_d;
    ovf_cmd_d.ins    = ok_d && is_add && wrap;
    ovf_cmd_d.strict = 1'b1;
  end

  assign status_d = reject;
  assign wrap_d   = ok_d && is_add && wrap;
  assign dl_out_d = (ok_d && is_add) ? 32'(dl) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else if (accept) begin
      pend_q <= 1'b1;
    end else if (apply) begin
      pend_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_cmd_q <= cur_cmd_d;
      ovf_cmd_q <= ovf_cmd_d;
      ok_q      <= ok_d;
      add_q     <= is_add;
      idx_q     <= idx_d;
      status_q  <= status_d;
      wrap_q    <= wrap_d;
      dl_out_q  <= dl_out_d;
    end
  end

  // rows only move on the apply cycle
  always_comb begin
    cur_cmd     = cur_cmd_q;
    ovf_cmd     = ovf_cmd_q;
    cur_cmd.ins = cur_cmd_q.ins && apply;
    cur_cmd.rem = cur_cmd_q.rem && apply;
    ovf_cmd.ins = ovf_cmd_q.ins && apply;
    ovf_cmd.rem = ovf_cmd_q.rem && apply;
  end

  stdq_row u_cur_row (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cur_cmd),
    .head_next_o (cur_head),
    .valid_o     (cur_valid)
  );

  stdq_row u_ovf_row (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ovf_cmd),
    .head_next_o (ovf_head),
    .valid_o     (ovf_valid)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
    end else if (apply && ok_q) begin
      run_q[idx_q] <= add_q;
    end
  end

  always_comb begin
    rsp_d                   = '0;
    rsp_d.status            = status_q;
    rsp_d.went_to_overflow  = wrap_q;
    rsp_d.deadline          = dl_out_q;
    rsp_d.current_nonempty  = cur_head.valid;
    rsp_d.current_head      = cur_head.valid ? cur_head.id : '0;
    rsp_d.overflow_nonempty = ovf_head.valid;
    rsp_d.overflow_head     = ovf_head.valid ? ovf_head.id : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (apply) begin
      rsp_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (apply) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = rsp_valid_q;
  assign out_rsp_o   = rsp_q;

  `STDQ_ASSERT(a_accept_pends, accept |=> pend_q, "request not held for update")
  `STDQ_ASSERT(a_rsp_from_pend, $rose(out_valid_o) |-> $past(pend_q), "result without request")
  `STDQ_ASSERT_ALWAYS(a_run_count,
    $countones(run_q) == ($countones(cur_valid) + $countones(ovf_valid)),
    "running timers disagree with list contents")
  `STDQ_ASSERT(a_rows_packed,
    ((((cur_valid + 1'b1) & cur_valid) == '0) && (((ovf_valid + 1'b1) & ovf_valid) == '0)),
    "gap in a cell row")

endmodule

`default_nettype wire
